// ===== design/qpp_pkg.sv =====
// shared types and constants of the quadrant photodiode position block
`default_nettype none
package qpp_pkg;

	localparam int MAX_CAL_SAMPLES_DEF = 256;
	localparam int SAMPLE_BITS_DEF     = 10;
	localparam int CHANNELS            = 4;
	localparam int Q8_SHIFT            = 8;
	localparam int OFFSET_SCALE        = 1000;
	localparam int OFFSET_W            = 11;

	// channel order within an item
	localparam logic [1:0] CH_TOP_RIGHT    = 2'd0;
	localparam logic [1:0] CH_TOP_LEFT     = 2'd1;
	localparam logic [1:0] CH_BOTTOM_LEFT  = 2'd2;
	localparam logic [1:0] CH_BOTTOM_RIGHT = 2'd3;

	typedef enum logic [1:0] {
		FUNC_DARK   = 2'd0,
		FUNC_CENTRE = 2'd1,
		FUNC_FINISH = 2'd2,
		FUNC_TRACK  = 2'd3
	} func_t;

endpackage
`default_nettype wire

// ===== design/quad_photodiode_position_top.sv =====
// top level of the quadrant photodiode position block
//
// Each input transaction carries a func code in s_tuser and four converter samples in s_tdata.
// Dark and centred samples are summed in the cycle they arrive. Finish calibration runs up to
// twelve divisions on one shared restoring divider that yields one quotient bit per cycle. A
// tracking sample runs four bit-serial multiplies and two divisions and then yields one result
// transaction; a total of zero skips the divisions. s_tready is high only while no item is
// at work. The result sits in an output register, so a new item may enter while it waits.
`default_nettype none
module quad_photodiode_position_top #(
	parameter int MAX_CAL_SAMPLES = qpp_pkg::MAX_CAL_SAMPLES_DEF,
	parameter int SAMPLE_BITS     = qpp_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	// sample_top_right, sample_top_left, sample_bottom_left, sample_bottom_right
	input  wire logic [((4*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
	// func
	input  wire logic [1:0]                              s_tuser,
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	// h_offset, v_offset, zero fill
	output logic [23:0]                                  m_tdata,
	// no_signal
	output logic [0:0]                                   m_tuser
);

	localparam int SW   = SAMPLE_BITS;
	localparam int CW   = $clog2(MAX_CAL_SAMPLES + 1);
	localparam int SUMW = SW + CW;
	localparam int GW   = SW + 9;
	localparam int PW   = SW + GW;
	localparam int SGW  = PW - qpp_pkg::Q8_SHIFT;
	localparam int TW   = SGW + 2;
	localparam int W    = 2 * SW + 14;
	localparam int DCW  = $clog2(W);
	localparam int OW   = qpp_pkg::OFFSET_W;

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_DARK = 8'b00000010,
		S_CENT = 8'b00000100,
		S_GAIN = 8'b00001000,
		S_MUL  = 8'b00010000,
		S_HDIV = 8'b00100000,
		S_VDIV = 8'b01000000,
		S_OUT  = 8'b10000000
	} state_t;

	state_t           state_q;
	logic [1:0]       ch_q;
	logic             busy_q;
	logic [DCW-1:0]   cnt_q;
	logic [SUMW-1:0]  dark_sum_q [qpp_pkg::CHANNELS];
	logic [SUMW-1:0]  cent_sum_q [qpp_pkg::CHANNELS];
	logic [CW-1:0]    dark_cnt_q;
	logic [CW-1:0]    cent_cnt_q;
	logic [SW-1:0]    base_q [qpp_pkg::CHANNELS];
	logic [GW-1:0]    gain_q [qpp_pkg::CHANNELS];
	logic             out_valid_q;

	logic [SW-1:0]    smp_q [qpp_pkg::CHANNELS];
	logic [SW-1:0]    resp_q [qpp_pkg::CHANNELS];
	logic [SGW-1:0]   sig_q [qpp_pkg::CHANNELS];
	logic [W-1:0]     rem_q, quo_q, dvs_q;
	logic [SW-1:0]    ma_q;
	logic [PW-1:0]    mb_q, acc_q;
	logic [OW-1:0]    h_q, v_q;
	logic             ns_q;
	logic [23:0]      out_data_q;
	logic             out_user_q;

	logic             accept, done, start, out_load, last_ch;
	logic [DCW-1:0]   last_cnt;
	logic [W:0]       rem_sh;
	logic             ge;
	logic [W-1:0]     rem_nx, quo_nx;
	logic [PW-1:0]    acc_nx;
	logic [W-1:0]     dvd_ld, dvs_ld;
	logic [SW+1:0]    rsum;
	logic [SW-1:0]    refv;
	logic [TW-1:0]    right, left, top, bottom, total;
	logic [TW-1:0]    hmag, vmag;
	logic             hneg, vneg;
	logic [OW-1:0]    qo;
	logic [SW-1:0]    cavg;
	logic [CW-1:0]    dn, cn;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign last_ch  = (ch_q == qpp_pkg::CH_BOTTOM_RIGHT);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_tready);

	// serial step of the divider and of the multiplier
	assign last_cnt = (state_q == S_MUL) ? DCW'(SW - 1) : DCW'(W - 1);
	assign done     = busy_q && (cnt_q == last_cnt);
	assign rem_sh   = {rem_q, quo_q[W-1]};
	assign ge       = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx   = ge ? W'(rem_sh - {1'b0, dvs_q}) : rem_sh[W-1:0];
	assign quo_nx   = {quo_q[W-2:0], ge};
	assign acc_nx   = acc_q + (ma_q[0] ? mb_q : '0);

	// averages treat a zero count as one
	assign dn   = (dark_cnt_q == '0) ? CW'(1) : dark_cnt_q;
	assign cn   = (cent_cnt_q == '0) ? CW'(1) : cent_cnt_q;
	assign cavg = quo_nx[SW-1:0];

	// mean reference response, zero taken as one
	assign rsum = (SW+2)'(resp_q[0]) + (SW+2)'(resp_q[1]) + (SW+2)'(resp_q[2])
		+ (SW+2)'(resp_q[3]);
	assign refv = (rsum[SW+1:2] == '0) ? SW'(1) : rsum[SW+1:2];

	// quadrant sums and signed differences as magnitude and sign
	assign right  = TW'(sig_q[qpp_pkg::CH_TOP_RIGHT]) + TW'(sig_q[qpp_pkg::CH_BOTTOM_RIGHT]);
	assign left   = TW'(sig_q[qpp_pkg::CH_TOP_LEFT]) + TW'(sig_q[qpp_pkg::CH_BOTTOM_LEFT]);
	assign top    = TW'(sig_q[qpp_pkg::CH_TOP_RIGHT]) + TW'(sig_q[qpp_pkg::CH_TOP_LEFT]);
	assign bottom = TW'(sig_q[qpp_pkg::CH_BOTTOM_LEFT]) + TW'(sig_q[qpp_pkg::CH_BOTTOM_RIGHT]);
	assign total  = right + left;
	assign hneg   = (left > right);
	assign vneg   = (bottom > top);
	assign hmag   = hneg ? (left - right) : (right - left);
	assign vmag   = vneg ? (bottom - top) : (top - bottom);
	assign qo     = quo_nx[OW-1:0];

	// operands for the next run of the serial unit
	always_comb begin
		start  = 1'b0;
		dvd_ld = '0;
		dvs_ld = '0;
		case (state_q)
			S_DARK: begin
				start  = !busy_q;
				dvd_ld = W'(dark_sum_q[ch_q]);
				dvs_ld = W'(dn);
			end
			S_CENT: begin
				start  = !busy_q;
				dvd_ld = W'(cent_sum_q[ch_q]);
				dvs_ld = W'(cn);
			end
			S_GAIN: begin
				start  = !busy_q && (resp_q[ch_q] != '0);
				dvd_ld = W'({refv, 8'd0}) + W'(resp_q[ch_q] >> 1);
				dvs_ld = W'(resp_q[ch_q]);
			end
			S_MUL: begin
				start = !busy_q;
			end
			S_HDIV: begin
				start  = !busy_q && (total != '0);
				dvd_ld = W'(hmag) * W'(qpp_pkg::OFFSET_SCALE);
				dvs_ld = W'(total);
			end
			S_VDIV: begin
				start  = !busy_q;
				dvd_ld = W'(vmag) * W'(qpp_pkg::OFFSET_SCALE);
				dvs_ld = W'(total);
			end
			default: begin
				start = 1'b0;
			end
		endcase
	end

	// sequencer and calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			dark_cnt_q  <= '0;
			cent_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < qpp_pkg::CHANNELS; c++) begin
				dark_sum_q[c] <= '0;
				cent_sum_q[c] <= '0;
				base_q[c]     <= '0;
				gain_q[c]     <= GW'(256);
			end
		end else begin
			// result register holds until its transaction completes
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCW'(1);
				if (done)
					busy_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ch_q <= '0;
						case (qpp_pkg::func_t'(s_tuser))
							qpp_pkg::FUNC_DARK: begin
								if (dark_cnt_q < CW'(MAX_CAL_SAMPLES)) begin
									for (int c = 0; c < qpp_pkg::CHANNELS; c++)
										dark_sum_q[c] <= dark_sum_q[c]
											+ SUMW'(s_tdata[c*SW +: SW]);
									dark_cnt_q <= dark_cnt_q + CW'(1);
								end
							end
							qpp_pkg::FUNC_CENTRE: begin
								if (cent_cnt_q < CW'(MAX_CAL_SAMPLES)) begin
									for (int c = 0; c < qpp_pkg::CHANNELS; c++)
										cent_sum_q[c] <= cent_sum_q[c]
											+ SUMW'(s_tdata[c*SW +: SW]);
									cent_cnt_q <= cent_cnt_q + CW'(1);
								end
							end
							qpp_pkg::FUNC_FINISH: state_q <= S_DARK;
							qpp_pkg::FUNC_TRACK:  state_q <= S_MUL;
							default:              state_q <= S_IDLE;
						endcase
					end
				end
				S_DARK: begin
					if (done) begin
						base_q[ch_q] <= quo_nx[SW-1:0];
						state_q      <= S_CENT;
					end
				end
				S_CENT: begin
					if (done) begin
						ch_q    <= ch_q + 2'd1;
						state_q <= last_ch ? S_GAIN : S_DARK;
					end
				end
				S_GAIN: begin
					if ((!busy_q && resp_q[ch_q] == '0) || done) begin
						gain_q[ch_q] <= done ? quo_nx[GW-1:0] : GW'(256);
						ch_q         <= ch_q + 2'd1;
						if (last_ch) begin
							state_q    <= S_IDLE;
							dark_cnt_q <= '0;
							cent_cnt_q <= '0;
							for (int c = 0; c < qpp_pkg::CHANNELS; c++) begin
								dark_sum_q[c] <= '0;
								cent_sum_q[c] <= '0;
							end
						end
					end
				end
				S_MUL: begin
					if (done) begin
						ch_q <= ch_q + 2'd1;
						if (last_ch)
							state_q <= S_HDIV;
					end
				end
				S_HDIV: begin
					if (!busy_q && total == '0)
						state_q <= S_OUT;
					else if (done)
						state_q <= S_VDIV;
				end
				S_VDIV: begin
					if (done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers of the serial unit and the result
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int c = 0; c < qpp_pkg::CHANNELS; c++)
				smp_q[c] <= s_tdata[c*SW +: SW];
		end
		if (start) begin
			rem_q <= '0;
			quo_q <= dvd_ld;
			dvs_q <= dvs_ld;
			acc_q <= '0;
			ma_q  <= (smp_q[ch_q] < base_q[ch_q]) ? (base_q[ch_q] - smp_q[ch_q]) : '0;
			mb_q  <= PW'(gain_q[ch_q]);
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			acc_q <= acc_nx;
			ma_q  <= ma_q >> 1;
			mb_q  <= mb_q << 1;
		end
		if (done && state_q == S_CENT)
			resp_q[ch_q] <= (cavg < base_q[ch_q]) ? (base_q[ch_q] - cavg) : '0;
		if (done && state_q == S_MUL)
			sig_q[ch_q] <= acc_nx[PW-1:qpp_pkg::Q8_SHIFT];
		if (state_q == S_HDIV && !busy_q && !start) begin
			h_q  <= '0;
			v_q  <= '0;
			ns_q <= 1'b1;
		end
		if (done && state_q == S_HDIV) begin
			h_q  <= hneg ? (OW'(0) - qo) : qo;
			ns_q <= 1'b0;
		end
		if (done && state_q == S_VDIV)
			v_q <= vneg ? (OW'(0) - qo) : qo;
		if (out_load) begin
			out_data_q <= {2'b00, v_q, h_q};
			out_user_q <= ns_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
`default_nettype wire

// ===== design/qpp_checker.sv =====
// port checker of the quadrant photodiode position block and its bind
`default_nettype none
module qpp_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          s_tvalid,
	input wire logic          s_tready,
	input wire logic          m_tvalid,
	input wire logic          m_tready,
	input wire logic [23:0]   m_tdata,
	input wire logic [0:0]    m_tuser
);

	// a waiting result stays until its transaction completes
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
	else $error("result dropped before transaction");

	// no signal gives zero offsets
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[21:0] == 22'd0)
	else $error("offsets nonzero with no signal");

	// offsets stay within the scale
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[10:0]) >= -11'sd1000 && $signed(m_tdata[10:0]) <= 11'sd1000
			&& $signed(m_tdata[21:11]) >= -11'sd1000 && $signed(m_tdata[21:11]) <= 11'sd1000))
	else $error("offset out of range");

	// the block goes busy only after taking an input transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
	else $error("ready fell without input transaction");

	// a new result follows only after an input transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
	else $error("result without work");

endmodule

bind quad_photodiode_position_top qpp_checker u_qpp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== sim/quad_photodiode_position_top_test.sv =====
// testbench of the quadrant photodiode position block: calibration and tracking checks
`timescale 1ns / 1ps
module quad_photodiode_position_top_test;

	localparam int CAL_MAX = qpp_pkg::MAX_CAL_SAMPLES_DEF;

	typedef struct packed {
		qpp_pkg::func_t func;
		logic [9:0]     br;
		logic [9:0]     bl;
		logic [9:0]     tl;
		logic [9:0]     tr;
	} sample_item_t;

	typedef struct packed {
		logic signed [10:0] h;
		logic signed [10:0] v;
		logic               no_sig;
	} position_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;

	quad_photodiode_position_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	// predictor state
	longint unsigned dark_acc[4], centred_acc[4], gain_q8[4];
	int unsigned     dark_n, centred_n, base_lvl[4];

	sample_item_t pending_items[$];
	position_t    expected_positions[$];
	int errors = 0;
	int n_results = 0, n_nosig = 0, n_cal = 0;
	bit hold_receiver = 1'b0;

	// apply one accepted transaction to the predictor
	task automatic predict_position(input sample_item_t it);
		int unsigned     s[4];
		longint unsigned dn, cn, ref_resp, sig[4], total;
		int unsigned     resp[4];
		longint          rt, lf, tp, bt, h, v;
		position_t       p;
		s[0] = it.tr; s[1] = it.tl; s[2] = it.bl; s[3] = it.br;
		case (it.func)
			qpp_pkg::FUNC_DARK: if (dark_n < CAL_MAX) begin
				for (int c = 0; c < 4; c++) dark_acc[c] += s[c];
				dark_n++;
			end
			qpp_pkg::FUNC_CENTRE: if (centred_n < CAL_MAX) begin
				for (int c = 0; c < 4; c++) centred_acc[c] += s[c];
				centred_n++;
			end
			qpp_pkg::FUNC_FINISH: begin
				dn = dark_n ? dark_n : 1;
				cn = centred_n ? centred_n : 1;
				ref_resp = 0;
				for (int c = 0; c < 4; c++) begin
					base_lvl[c] = dark_acc[c] / dn;
					resp[c] = (centred_acc[c] / cn < base_lvl[c]) ?
						base_lvl[c] - centred_acc[c] / cn : 0;
					ref_resp += resp[c];
				end
				ref_resp /= 4;
				if (ref_resp == 0) ref_resp = 1;
				for (int c = 0; c < 4; c++)
					gain_q8[c] = resp[c] == 0 ? 256 : (ref_resp * 256 + resp[c] / 2) / resp[c];
				for (int c = 0; c < 4; c++) begin
					dark_acc[c] = 0; centred_acc[c] = 0;
				end
				dark_n = 0; centred_n = 0;
				n_cal++;
			end
			default: begin
				total = 0;
				for (int c = 0; c < 4; c++) begin
					sig[c] = ((s[c] < base_lvl[c]) ? base_lvl[c] - s[c] : 0) * gain_q8[c] / 256;
					total += sig[c];
				end
				rt = sig[0] + sig[3]; lf = sig[1] + sig[2];
				tp = sig[0] + sig[1]; bt = sig[2] + sig[3];
				h = 0; v = 0;
				if (total > 0) begin
					h = ((rt - lf) * 1000) / longint'(total);
					v = ((tp - bt) * 1000) / longint'(total);
				end
				p.h = h[10:0]; p.v = v[10:0]; p.no_sig = (total == 0);
				expected_positions.push_back(p);
			end
		endcase
	endtask

	function automatic sample_item_t make_item(qpp_pkg::func_t f, int tr, int tl, int bl,
		int br);
		sample_item_t it;
		it.func = f; it.tr = tr; it.tl = tl; it.bl = bl; it.br = br;
		return it;
	endfunction

	function automatic int unsigned gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// light sample around a level, clipped to the converter range
	function automatic int unsigned near(int lvl, int spread);
		int x;
		x = lvl + $signed($urandom_range(0, 2 * spread)) - spread;
		if (x < 0) x = 0;
		if (x > 1023) x = 1023;
		return x;
	endfunction

	// driver: offers queued transactions with random gaps
	int unsigned drv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			drv_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_position(sample_item_t'({s_tuser, s_tdata}));
				void'(pending_items.pop_front());
				drv_gap = gap_len();
			end
			if (drv_gap > 0) begin
				drv_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				s_tvalid <= 1'b1;
				{s_tuser, s_tdata} <= pending_items[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: random back-pressure and field compare
	int unsigned mon_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		position_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			mon_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (expected_positions.size() == 0) begin
					$error("result transaction with no expectation: %h", m_tdata);
					errors++;
				end else begin
					want = expected_positions.pop_front();
					if (m_tdata[10:0] !== want.h) begin
						$error("h_offset expected %0d actual %0d", want.h, $signed(m_tdata[10:0]));
						errors++;
					end
					if (m_tdata[21:11] !== want.v) begin
						$error("v_offset expected %0d actual %0d", want.v, $signed(m_tdata[21:11]));
						errors++;
					end
					if (m_tuser[0] !== want.no_sig) begin
						$error("no_signal expected %0d actual %0d", want.no_sig, m_tuser[0]);
						errors++;
					end
					if (want.no_sig) n_nosig++;
				end
				mon_gap = gap_len();
			end
			if (hold_receiver) begin
				m_tready <= 1'b0;
			end else if (mon_gap > 0) begin
				mon_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		while (pending_items.size() > 0 || expected_positions.size() > 0) @(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	// one calibration run with random lighting followed by mostly tracking samples, some with a random func
	task automatic queue_session(int n_dark, int n_cent, int n_track);
		int dl[4], cl[4];
		for (int c = 0; c < 4; c++) begin
			dl[c] = $urandom_range(500, 1023);
			cl[c] = $urandom_range(0, dl[c]);
		end
		for (int k = 0; k < n_dark; k++)
			pending_items.push_back(make_item(qpp_pkg::FUNC_DARK, near(dl[0], 8),
				near(dl[1], 8), near(dl[2], 8), near(dl[3], 8)));
		for (int k = 0; k < n_cent; k++)
			pending_items.push_back(make_item(qpp_pkg::FUNC_CENTRE, near(cl[0], 8),
				near(cl[1], 8), near(cl[2], 8), near(cl[3], 8)));
		pending_items.push_back(make_item(qpp_pkg::FUNC_FINISH, $urandom_range(0, 1023),
			$urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023)));
		for (int k = 0; k < n_track; k++) begin
			if ($urandom_range(0, 9) == 0)
				pending_items.push_back(make_item(qpp_pkg::func_t'($urandom_range(0, 3)),
					$urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 1023)));
			else
				pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, near(cl[0], 300),
					near(cl[1], 300), near(cl[2], 300), near(cl[3], 300)));
		end
	endtask

	initial begin
		for (int c = 0; c < 4; c++) begin
			dark_acc[c] = 0; centred_acc[c] = 0; base_lvl[c] = 0; gain_q8[c] = 256;
		end
		dark_n = 0; centred_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: uncalibrated tracking, extremes, empty calibration
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 0, 0, 0, 0));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 1023, 1023, 1023, 1023));
		pending_items.push_back(make_item(qpp_pkg::FUNC_FINISH, 1023, 0, 1023, 0));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 0, 1023, 0, 1023));
		pending_items.push_back(make_item(qpp_pkg::FUNC_DARK, 1023, 1023, 1023, 1023));
		pending_items.push_back(make_item(qpp_pkg::FUNC_DARK, 1023, 1022, 1021, 1000));
		pending_items.push_back(make_item(qpp_pkg::FUNC_CENTRE, 100, 1023, 0, 400));
		pending_items.push_back(make_item(qpp_pkg::FUNC_FINISH, 0, 0, 0, 0));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 0, 0, 0, 0));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 0, 1023, 1023, 1023));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 1023, 0, 1023, 1023));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 1023, 1023, 0, 1023));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 1023, 1023, 1023, 0));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 1023, 1023, 1023, 1023));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 682, 341, 1023, 0));
		// centred darker than dark: zero responses
		pending_items.push_back(make_item(qpp_pkg::FUNC_DARK, 0, 0, 0, 0));
		pending_items.push_back(make_item(qpp_pkg::FUNC_CENTRE, 1023, 1023, 1023, 1023));
		pending_items.push_back(make_item(qpp_pkg::FUNC_FINISH, 0, 0, 0, 0));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 0, 0, 0, 0));
		wait_drained();

		// calibration full: more dark and centred samples than the limit
		for (int k = 0; k < CAL_MAX + 4; k++)
			pending_items.push_back(make_item(qpp_pkg::FUNC_DARK, k < CAL_MAX ? 900 : 0, 1000,
				950, k < CAL_MAX ? 980 : 0));
		for (int k = 0; k < CAL_MAX + 3; k++)
			pending_items.push_back(make_item(qpp_pkg::FUNC_CENTRE, k < CAL_MAX ? 300 : 1023,
				500, 600, 200));
		pending_items.push_back(make_item(qpp_pkg::FUNC_FINISH, 0, 0, 0, 0));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 300, 500, 600, 200));
		pending_items.push_back(make_item(qpp_pkg::FUNC_TRACK, 0, 0, 0, 0));
		wait_drained();

		// receiver holds off while the sender keeps offering
		queue_session(3, 3, 20);
		hold_receiver = 1'b1;
		repeat (3000) @(posedge clk);
		hold_receiver = 1'b0;
		wait_drained();

		// random sessions
		for (int sess = 0; sess < 3; sess++)
			queue_session($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(5, 35));
		wait_drained();

		$display("covered %0d calibrations and %0d tracking results (%0d without signal)",
			n_cal, n_results, n_nosig);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// timeout
	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
